// ===== design/bez_pkg.sv =====
// Shared constants and types of the cubic Bezier evaluator.
`default_nettype none
package bez_pkg;

  localparam int COORD_BITS_DEF  = 16;
  localparam int T_FRAC_BITS_DEF = 16;
  localparam int OUT_W           = 27;
  localparam int OUT_Q           = 8;
  localparam int NUM_CELLS       = 4;
  localparam int NUM_REGS        = 8;
  localparam int REG_IDX_W       = $clog2(NUM_REGS);
  localparam int CFG_IDX_W       = REG_IDX_W + 1;

  localparam logic [1:0] OP_POS  = 2'd0;
  localparam logic [1:0] OP_TAN  = 2'd1;
  localparam logic [1:0] OP_PERP = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_X0 = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_Y0 = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_X1 = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_Y1 = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_X2 = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_Y2 = REG_IDX_W'(5);
  localparam logic [REG_IDX_W-1:0] REG_X3 = REG_IDX_W'(6);
  localparam logic [REG_IDX_W-1:0] REG_Y3 = REG_IDX_W'(7);

  typedef struct packed {
    logic       valid;
    logic [1:0] op;
  } ctl_t;

endpackage
`default_nettype wire

// ===== design/bez_coef.sv =====
// Polynomial coefficients of one axis for position and derivative evaluation.
`default_nettype none
module bez_coef #(
  parameter int COORD_BITS = 16,
  parameter int COEF_W     = 21
) (
  input  wire logic                     clk,
  input  wire logic signed [COORD_BITS-1:0] p0,
  input  wire logic signed [COORD_BITS-1:0] p1,
  input  wire logic signed [COORD_BITS-1:0] p2,
  input  wire logic signed [COORD_BITS-1:0] p3,
  output logic signed [COEF_W-1:0]      pcoef [bez_pkg::NUM_CELLS],
  output logic signed [COEF_W-1:0]      dcoef [bez_pkg::NUM_CELLS]
);
  import bez_pkg::*;

  logic signed [COEF_W-1:0] e0, e1, e2, e3;
  logic signed [COEF_W-1:0] c1, c2, c3;

  always_comb begin
    e0 = COEF_W'(p0);
    e1 = COEF_W'(p1);
    e2 = COEF_W'(p2);
    e3 = COEF_W'(p3);
    c1 = COEF_W'(3 * (e1 - e0));
    c2 = COEF_W'(3 * e0 - 6 * e1 + 3 * e2);
    c3 = COEF_W'(3 * (e1 - e2) + e3 - e0);
  end

  always_ff @(posedge clk) begin
    pcoef[0] <= c3;
    pcoef[1] <= c2;
    pcoef[2] <= c1;
    pcoef[3] <= e0;
    dcoef[0] <= '0;
    dcoef[1] <= COEF_W'(3 * c3);
    dcoef[2] <= COEF_W'(2 * c2);
    dcoef[3] <= c1;
  end

endmodule
`default_nettype wire

// ===== design/bez_cell.sv =====
// One Horner step for both axes: multiply by t, round, add coefficient.
`default_nettype none
module bez_cell #(
  parameter int T_FRAC_BITS = 16,
  parameter int COEF_W      = 21,
  parameter int ACC_W       = 38
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire bez_pkg::ctl_t              ctl_in,
  input  wire logic [T_FRAC_BITS:0]       t_in,
  input  wire logic signed [ACC_W-1:0]    acc_x_in,
  input  wire logic signed [ACC_W-1:0]    acc_y_in,
  input  wire logic signed [COEF_W-1:0]   pcoef_x,
  input  wire logic signed [COEF_W-1:0]   dcoef_x,
  input  wire logic signed [COEF_W-1:0]   pcoef_y,
  input  wire logic signed [COEF_W-1:0]   dcoef_y,
  output bez_pkg::ctl_t                   ctl_out,
  output logic [T_FRAC_BITS:0]            t_out,
  output logic signed [ACC_W-1:0]         acc_x_out,
  output logic signed [ACC_W-1:0]         acc_y_out
);
  import bez_pkg::*;

  localparam int P_W = ACC_W + T_FRAC_BITS + 1;
  localparam int K_EXT = P_W - COEF_W - 2 * T_FRAC_BITS;

  ctl_t                     ctl1;
  logic [T_FRAC_BITS:0]     t1;
  logic signed [P_W-1:0]    prod_x, prod_y;
  logic signed [P_W-1:0]    ax, ay, tx;
  logic signed [COEF_W-1:0] sel_x, sel_y;
  logic signed [P_W-1:0]    k_x, k_y, sum_x, sum_y;

  always_comb begin
    ax = P_W'(acc_x_in);
    ay = P_W'(acc_y_in);
    tx = P_W'($signed({1'b0, t_in}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
    end else begin
      ctl1 <= ctl_in;
    end
    t1     <= t_in;
    prod_x <= ax * tx;
    prod_y <= ay * tx;
  end

  always_comb begin
    sel_x = (ctl1.op == OP_POS) ? pcoef_x : dcoef_x;
    sel_y = (ctl1.op == OP_POS) ? pcoef_y : dcoef_y;
    k_x   = $signed({{K_EXT{sel_x[COEF_W-1]}}, sel_x, {T_FRAC_BITS{1'b0}},
                     1'b1, {(T_FRAC_BITS-1){1'b0}}});
    k_y   = $signed({{K_EXT{sel_y[COEF_W-1]}}, sel_y, {T_FRAC_BITS{1'b0}},
                     1'b1, {(T_FRAC_BITS-1){1'b0}}});
    sum_x = prod_x + k_x - $signed({{(P_W-1){1'b0}}, prod_x[P_W-1]});
    sum_y = prod_y + k_y - $signed({{(P_W-1){1'b0}}, prod_y[P_W-1]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl1;
    end
    t_out     <= t1;
    acc_x_out <= sum_x[ACC_W+T_FRAC_BITS-1:T_FRAC_BITS];
    acc_y_out <= sum_y[ACC_W+T_FRAC_BITS-1:T_FRAC_BITS];
  end

endmodule
`default_nettype wire

// ===== design/bez_out.sv =====
// Result stage: rescale to Q.8, apply the op, saturate to the output range.
`default_nettype none
module bez_out #(
  parameter int T_FRAC_BITS = 16,
  parameter int ACC_W       = 38
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire bez_pkg::ctl_t               ctl_in,
  input  wire logic signed [ACC_W-1:0]     acc_x,
  input  wire logic signed [ACC_W-1:0]     acc_y,
  output logic                             done,
  output logic signed [bez_pkg::OUT_W-1:0] out_x,
  output logic signed [bez_pkg::OUT_W-1:0] out_y
);
  import bez_pkg::*;

  localparam int SH  = T_FRAC_BITS - OUT_Q;
  localparam int Q_W = ACC_W - SH;
  localparam int S_W = (Q_W + 1 > OUT_W) ? Q_W + 1 : OUT_W + 1;
  localparam logic signed [S_W-1:0] HI = (S_W'(1) <<< (OUT_W - 1)) - S_W'(1);
  localparam logic signed [S_W-1:0] LO = -(S_W'(1) <<< (OUT_W - 1));

  ctl_t                    ctl1;
  logic signed [Q_W-1:0]   qx, qy;
  logic signed [Q_W-1:0]   qx_next, qy_next;
  logic signed [S_W-1:0]   wx, wy, vx, vy;

  function automatic logic signed [OUT_W-1:0] sat(input logic signed [S_W-1:0] v);
    logic signed [S_W-1:0] c;
    c = v;
    if (v > HI) begin
      c = HI;
    end else if (v < LO) begin
      c = LO;
    end
    return c[OUT_W-1:0];
  endfunction

  generate
    if (SH > 0) begin : g_round
      localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (SH - 1);
      logic signed [ACC_W-1:0] rx, ry;
      always_comb begin
        rx      = acc_x + RND - $signed({{(ACC_W-1){1'b0}}, acc_x[ACC_W-1]});
        ry      = acc_y + RND - $signed({{(ACC_W-1){1'b0}}, acc_y[ACC_W-1]});
        qx_next = rx[ACC_W-1:SH];
        qy_next = ry[ACC_W-1:SH];
      end
    end else begin : g_pass
      always_comb begin
        qx_next = acc_x;
        qy_next = acc_y;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
    end else begin
      ctl1 <= ctl_in;
    end
    qx <= qx_next;
    qy <= qy_next;
  end

  always_comb begin
    wx = S_W'(qx);
    wy = S_W'(qy);
    unique case (ctl1.op)
      OP_POS, OP_TAN: begin
        vx = wx;
        vy = wy;
      end
      OP_PERP: begin
        vx = -wy;
        vy = wx;
      end
      default: begin
        vx = '0;
        vy = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl1.valid;
    end
    out_x <= sat(vx);
    out_y <= sat(vy);
  end

endmodule
`default_nettype wire

// ===== design/cubic_bezier_evaluator.sv =====
// Top level of the cubic Bezier evaluator: config registers, cell chain, result stage.
//
//   channel   signals                              direction  handshake
//   item in   start, busy, op, t_param             in         start && !busy
//   config    cfg_valid, cfg_ready, cfg_index,     in         cfg_valid && cfg_ready
//             cfg_data
//   result    done, out_x, out_y                   out        done, one cycle, no stall
//
// One item is taken every cycle while rst is low; each result passes through the input
// register, two stages in each of the four Horner cells and two result stages.
// The cell chain sets the latency; the multiplier in each cell sets the clock.
// Reset is synchronous; busy and !cfg_ready are high only while rst is high.
// Config registers clear to zero; indexes beyond the last register are dropped.
`default_nettype none
module cubic_bezier_evaluator #(
  parameter int COORD_BITS  = bez_pkg::COORD_BITS_DEF,
  parameter int T_FRAC_BITS = bez_pkg::T_FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [1:0]                      op,
  input  wire logic [T_FRAC_BITS:0]            t_param,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bez_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [COORD_BITS-1:0]           cfg_data,
  output logic                                 done,
  output logic signed [bez_pkg::OUT_W-1:0]     out_x,
  output logic signed [bez_pkg::OUT_W-1:0]     out_y
);
  import bez_pkg::*;

  localparam int COEF_W = COORD_BITS + 5;
  localparam int ACC_W  = COORD_BITS + T_FRAC_BITS + 6;
  localparam int LAT    = 2 * NUM_CELLS + 3;
  localparam logic [T_FRAC_BITS:0] T_ONE = (T_FRAC_BITS + 1)'(1) << T_FRAC_BITS;

  logic signed [COORD_BITS-1:0] ctrl [NUM_REGS];
  logic signed [COEF_W-1:0]     pcoef_x [NUM_CELLS];
  logic signed [COEF_W-1:0]     dcoef_x [NUM_CELLS];
  logic signed [COEF_W-1:0]     pcoef_y [NUM_CELLS];
  logic signed [COEF_W-1:0]     dcoef_y [NUM_CELLS];

  ctl_t                     ctl_c [NUM_CELLS+1];
  logic [T_FRAC_BITS:0]     t_c   [NUM_CELLS+1];
  logic signed [ACC_W-1:0]  accx_c [NUM_CELLS+1];
  logic signed [ACC_W-1:0]  accy_c [NUM_CELLS+1];

  assign busy      = rst;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        ctrl[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      ctrl[cfg_index[REG_IDX_W-1:0]] <= cfg_data;
    end
  end

  bez_coef #(.COORD_BITS(COORD_BITS), .COEF_W(COEF_W)) u_coef_x (
    .clk   (clk),
    .p0    (ctrl[REG_X0]),
    .p1    (ctrl[REG_X1]),
    .p2    (ctrl[REG_X2]),
    .p3    (ctrl[REG_X3]),
    .pcoef (pcoef_x),
    .dcoef (dcoef_x)
  );

  bez_coef #(.COORD_BITS(COORD_BITS), .COEF_W(COEF_W)) u_coef_y (
    .clk   (clk),
    .p0    (ctrl[REG_Y0]),
    .p1    (ctrl[REG_Y1]),
    .p2    (ctrl[REG_Y2]),
    .p3    (ctrl[REG_Y3]),
    .pcoef (pcoef_y),
    .dcoef (dcoef_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_c[0] <= '0;
    end else begin
      ctl_c[0].valid <= start && !busy;
      ctl_c[0].op    <= op;
    end
    t_c[0] <= (t_param > T_ONE) ? T_ONE : t_param;
  end

  assign accx_c[0] = '0;
  assign accy_c[0] = '0;

  generate
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      bez_cell #(
        .T_FRAC_BITS (T_FRAC_BITS),
        .COEF_W      (COEF_W),
        .ACC_W       (ACC_W)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl_in    (ctl_c[k]),
        .t_in      (t_c[k]),
        .acc_x_in  (accx_c[k]),
        .acc_y_in  (accy_c[k]),
        .pcoef_x   (pcoef_x[k]),
        .dcoef_x   (dcoef_x[k]),
        .pcoef_y   (pcoef_y[k]),
        .dcoef_y   (dcoef_y[k]),
        .ctl_out   (ctl_c[k+1]),
        .t_out     (t_c[k+1]),
        .acc_x_out (accx_c[k+1]),
        .acc_y_out (accy_c[k+1])
      );
    end
  endgenerate

  bez_out #(.T_FRAC_BITS(T_FRAC_BITS), .ACC_W(ACC_W)) u_out (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (ctl_c[NUM_CELLS]),
    .acc_x  (accx_c[NUM_CELLS]),
    .acc_y  (accy_c[NUM_CELLS]),
    .done   (done),
    .out_x  (out_x),
    .out_y  (out_y)
  );

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done == $past(start && !busy, LAT))
    else $error("result strobe does not follow item by pipeline latency");

  a_unused_op: assert property (@(posedge clk) disable iff (rst)
    (done && !($past(op, LAT) == OP_POS || $past(op, LAT) == OP_TAN ||
               $past(op, LAT) == OP_PERP)) |-> (out_x == '0 && out_y == '0))
    else $error("undefined op gave a nonzero result");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the cubic Bezier evaluator: random and directed stream with checking.
`timescale 1ns / 1ps
module tb_top;
  import bez_pkg::*;

  localparam int COORD = COORD_BITS_DEF;
  localparam int T_FRAC = T_FRAC_BITS_DEF;
  localparam int T_BITS = T_FRAC + 1;
  localparam longint unsigned T_ONE = 64'd1 << T_FRAC;
  localparam longint OUT_HI = (64'sd1 <<< (OUT_W - 1)) - 1;
  localparam longint OUT_LO = -(64'sd1 <<< (OUT_W - 1));
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = CFG_IDX_W'(NUM_REGS);
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = {CFG_IDX_W{1'b1}};
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 230;

  typedef struct {
    logic [1:0]        op;
    logic [T_BITS-1:0] t;
  } sample_t;

  typedef struct {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] op = OP_POS;
  logic [T_BITS-1:0] t_param = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD-1:0] cfg_data = '0;
  logic done;
  logic signed [OUT_W-1:0] out_x;
  logic signed [OUT_W-1:0] out_y;

  logic [COORD-1:0] coord_reg [NUM_REGS];
  sample_t samples_to_send [$];
  point_t points_due [$];
  int gap_left = 0;
  bit no_gaps = 1'b0;
  int items_sent = 0;
  int points_checked = 0;
  int mismatches = 0;
  int settings_used = 0;

  cubic_bezier_evaluator dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint scale_by_t(longint acc, longint unsigned t);
    longint unsigned mag;
    mag = (acc < 0) ? longint'(-acc) : longint'(acc);
    mag = (mag * t + (64'd1 << (T_FRAC - 1))) >> T_FRAC;
    return (acc < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint bezier_axis(int axis, longint unsigned t, bit slope);
    longint p0, p1, p2, p3, c0, c1, c2, c3, acc, one;
    longint unsigned mag;
    p0 = longint'($signed(coord_reg[REG_IDX_W'(int'(REG_X0) + axis)]));
    p1 = longint'($signed(coord_reg[REG_IDX_W'(int'(REG_X1) + axis)]));
    p2 = longint'($signed(coord_reg[REG_IDX_W'(int'(REG_X2) + axis)]));
    p3 = longint'($signed(coord_reg[REG_IDX_W'(int'(REG_X3) + axis)]));
    one = longint'(T_ONE);
    c0 = p0;
    c1 = -3 * p0 + 3 * p1;
    c2 = 3 * p0 - 6 * p1 + 3 * p2;
    c3 = -p0 + 3 * p1 - 3 * p2 + p3;
    if (slope) begin
      acc = 3 * c3 * one;
      acc = 2 * c2 * one + scale_by_t(acc, t);
      acc = c1 * one + scale_by_t(acc, t);
    end else begin
      acc = c3 * one;
      acc = c2 * one + scale_by_t(acc, t);
      acc = c1 * one + scale_by_t(acc, t);
      acc = c0 * one + scale_by_t(acc, t);
    end
    mag = (acc < 0) ? longint'(-acc) : longint'(acc);
    mag = (mag + (64'd1 << (T_FRAC - OUT_Q - 1))) >> (T_FRAC - OUT_Q);
    return (acc < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_out(longint v);
    if (v > OUT_HI) return OUT_W'(OUT_HI);
    if (v < OUT_LO) return OUT_W'(OUT_LO);
    return OUT_W'(v);
  endfunction

  function automatic point_t predict_point(logic [1:0] code, logic [T_BITS-1:0] t_in);
    longint unsigned t;
    point_t r;
    t = (t_in > T_ONE) ? T_ONE : longint'(t_in);
    r.x = '0;
    r.y = '0;
    case (code)
      OP_POS: begin
        r.x = clamp_out(bezier_axis(0, t, 1'b0));
        r.y = clamp_out(bezier_axis(1, t, 1'b0));
      end
      OP_TAN: begin
        r.x = clamp_out(bezier_axis(0, t, 1'b1));
        r.y = clamp_out(bezier_axis(1, t, 1'b1));
      end
      OP_PERP: begin
        r.x = clamp_out(-bezier_axis(1, t, 1'b1));
        r.y = clamp_out(bezier_axis(0, t, 1'b1));
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        points_due.push_back(predict_point(op, t_param));
        items_sent++;
      end
      if (start && busy) begin
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (!no_gaps && $urandom_range(0, 11) == 0) begin
        gap_left = $urandom_range(1, 9) - 1;
        start <= 1'b0;
      end else if (samples_to_send.size() != 0) begin
        sample_t s;
        s = samples_to_send.pop_front();
        start <= 1'b1;
        op <= s.op;
        t_param <= s.t;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (points_due.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d", $time, out_x, out_y);
        mismatches++;
      end else begin
        point_t want;
        want = points_due.pop_front();
        if (out_x !== want.x) begin
          $display("%0t: out_x expected %0d actual %0d", $time, want.x, out_x);
          mismatches++;
        end
        if (out_y !== want.y) begin
          $display("%0t: out_y expected %0d actual %0d", $time, want.y, out_y);
          mismatches++;
        end
        points_checked++;
      end
    end
  end

  task automatic queue_sample(input logic [1:0] code, input logic [T_BITS-1:0] t);
    sample_t s;
    s.op = code;
    s.t = t;
    samples_to_send.push_back(s);
  endtask

  task automatic load_coord(input logic [CFG_IDX_W-1:0] idx, input logic [COORD-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx < NUM_REGS) coord_reg[idx[REG_IDX_W-1:0]] = value;
  endtask

  task automatic wait_drained;
    do @(negedge clk); while (samples_to_send.size() != 0 || start || points_due.size() != 0);
  endtask

  function automatic logic [COORD-1:0] pick_coord;
    case ($urandom_range(0, 7))
      0: return {1'b1, {(COORD - 1){1'b0}}};
      1: return {1'b0, {(COORD - 1){1'b1}}};
      2: return '0;
      3: return COORD'($urandom_range(0, 15)) - COORD'(8);
      default: return COORD'($urandom);
    endcase
  endfunction

  function automatic logic [T_BITS-1:0] pick_t;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return T_BITS'(1);
          2: return T_BITS'(T_ONE - 1);
          default: return T_BITS'(T_ONE);
        endcase
      end
      1: return T_BITS'($urandom_range(int'(T_ONE) + 1, (1 << T_BITS) - 1));
      default: return T_BITS'($urandom_range(0, int'(T_ONE)));
    endcase
  endfunction

  function automatic logic [1:0] pick_op;
    if ($urandom_range(0, 19) == 0) return OP_NONE;
    case ($urandom_range(0, 2))
      0: return OP_POS;
      1: return OP_TAN;
      default: return OP_PERP;
    endcase
  endfunction

  initial begin
    logic [1:0] ops [4];
    logic [T_BITS-1:0] ts [6];
    ops = '{OP_POS, OP_TAN, OP_PERP, OP_NONE};
    ts = '{'0, T_BITS'(1), T_BITS'(T_ONE / 2), T_BITS'(T_ONE - 1), T_BITS'(T_ONE), '1};
    foreach (coord_reg[i]) coord_reg[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (ops[i]) queue_sample(ops[i], T_BITS'($urandom_range(0, int'(T_ONE))));
    wait_drained();

    load_coord(CFG_IDX_W'(REG_X0), 16'h8000);
    load_coord(CFG_IDX_W'(REG_Y0), 16'h7fff);
    load_coord(CFG_IDX_W'(REG_X1), 16'h7fff);
    load_coord(CFG_IDX_W'(REG_Y1), 16'h8000);
    load_coord(CFG_IDX_W'(REG_X2), 16'h8000);
    load_coord(CFG_IDX_W'(REG_Y2), 16'h7fff);
    load_coord(CFG_IDX_W'(REG_X3), 16'h7fff);
    load_coord(CFG_IDX_W'(REG_Y3), 16'h8000);
    load_coord(IDX_SPARE_LO, 16'h1234);
    load_coord(IDX_SPARE_HI, 16'hedcb);
    settings_used++;
    foreach (ops[i]) foreach (ts[j]) queue_sample(ops[i], ts[j]);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      for (int r = 0; r < NUM_REGS; r++) load_coord(CFG_IDX_W'(r), pick_coord());
      if ($urandom_range(0, 1) == 0)
        load_coord(IDX_SPARE_LO + CFG_IDX_W'($urandom_range(0, NUM_REGS - 1)), COORD'($urandom));
      settings_used++;
      no_gaps = (p == PHASES - 1);
      for (int k = 0; k < PHASE_ITEMS; k++) queue_sample(pick_op(), pick_t());
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Ran %0d items through %0d control-point settings, all ops and t edges included;",
             items_sent, settings_used);
    $display("%0d results checked, %0d mismatches.", points_checked, mismatches);
    if (mismatches == 0 && points_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
design/bez_pkg.sv
design/bez_coef.sv
design/bez_cell.sv
design/bez_out.sv
design/cubic_bezier_evaluator.sv
tb/sv/tb_top.sv
